[rtl/fpfm_pkg.sv]
// shared constants, types and register codes of the frame pacer and fps meter
`timescale 1ns / 1ps
package fpfm_pkg;

  localparam int unsigned WINDOW     = 256;
  localparam int unsigned PTR_W      = $clog2(WINDOW);
  localparam int unsigned FILL_W     = $clog2(WINDOW + 1);
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned SUM_W      = DELTA_W + FILL_W;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS_W       = 10;
  localparam int unsigned FPS_W      = 10;
  localparam int unsigned FPS_SCALE  = 1000;
  localparam int unsigned PERIOD_RST = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned REM_W      = DELTA_W;
  localparam int unsigned CNT_W      = $clog2(SUM_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAUSED       = 2'd0,
    REG_SLOW_MOTION  = 2'd1,
    REG_FRAME_PERIOD = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD_AVG,
    ST_DIV_AVG,
    ST_LOAD_FPS,
    ST_DIV_FPS,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic upd_en;
    logic ld_avg;
    logic ld_fps;
    logic div_step;
    logic out_load;
  } ctrl_t;

endpackage

[rtl/fpfm_in_if.sv]
// frame tick channel carrying the real-time timestamp
`timescale 1ns / 1ps
interface fpfm_in_if import fpfm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

[rtl/fpfm_out_if.sv]
// result channel with delta, game time, sleep, average and fps
`timescale 1ns / 1ps
interface fpfm_out_if import fpfm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DELTA_W-1:0]  game_delta;
  logic [TIME_W-1:0]   game_time;
  logic [MS_W-1:0]     sleep_ms;
  logic [DELTA_W-1:0]  average_delta;
  logic [FPS_W-1:0]    frames_per_second;

  modport source (output valid, output game_delta, output game_time, output sleep_ms,
                  output average_delta, output frames_per_second, input ready);
  modport sink (input valid, input game_delta, input game_time, input sleep_ms,
                input average_delta, input frames_per_second, output ready);
endinterface

[rtl/fpfm_cfg_if.sv]
// configuration write channel with register index and write data
`timescale 1ns / 1ps
interface fpfm_cfg_if import fpfm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink (input valid, input reg_idx, input wdata, output ready);
endinterface

[rtl/fpfm_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module fpfm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/frame_pacer_fps_meter.sv]
// frame pacer and sliding-window fps meter, top level
//
// in_i carries one frame tick per word with a millisecond timestamp. Each
// tick yields exactly one word on out_o: saturated game delta, running game
// time, sleep time, windowed mean delta and frames per second.
// cfg_i writes paused (0), slow_motion (1) and frame_period_ms (2); it is
// always ready, unknown indexes are dropped.
// Each accepted tick runs through the sequencer: an update state writes the
// delta ring and the window sum, then a shared restoring divider, one
// quotient bit per cycle, runs 25 steps for the mean and 10 steps for
// 1000 / mean, with a load state before each run, and a finish state loads
// the result register.
// in_i is ready only in the idle state, so one tick is in work at a time and
// no new tick is accepted until the sequencer is back in idle.
// The result register lets a new tick start while the last result waits.
// If out_o stalls, the finished result holds in the sequencer until the
// result register frees up.
// Reset clears the timestamp, game time, ring pointer, fill count, sum and
// configuration (period 40 ms); the ring itself is not cleared, the fill
// count keeps unwritten entries from being used.
`timescale 1ns / 1ps
module frame_pacer_fps_meter import fpfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  fpfm_in_if.sink           in_i,
  fpfm_out_if.source        out_o,
  fpfm_cfg_if.sink          cfg_i
);

  state_e              state_q, state_d;
  ctrl_t               ctrl;

  logic                paused_q;
  logic                slow_q;
  logic [MS_W-1:0]     period_q;

  logic [TIME_W-1:0]   last_q;
  logic [TIME_W-1:0]   total_q;
  logic [DELTA_W-1:0]  g_q;
  logic [MS_W-1:0]     sleep_q;
  logic [PTR_W-1:0]    ptr_q;
  logic [FILL_W-1:0]   fill_q;
  logic [SUM_W-1:0]    sum_q;
  logic [DELTA_W-1:0]  avg_q;

  logic [REM_W-1:0]    rem_q;
  logic [SUM_W-1:0]    dvd_q;
  logic [SUM_W-1:0]    quo_q;
  logic [REM_W-1:0]    dvs_q;
  logic [CNT_W-1:0]    cnt_q;

  logic                out_valid_q;
  logic [DELTA_W-1:0]  out_delta_q;
  logic [TIME_W-1:0]   out_time_q;
  logic [MS_W-1:0]     out_sleep_q;
  logic [DELTA_W-1:0]  out_avg_q;
  logic [FPS_W-1:0]    out_fps_q;

  logic [TIME_W-1:0]   real_delta;
  logic [TIME_W-1:0]   sel_delta;
  logic [DELTA_W-1:0]  g_d;
  logic                full;
  logic [DELTA_W-1:0]  ring_rdata;
  logic [SUM_W-1:0]    sum_d;
  logic [MS_W-1:0]     sleep_d;
  logic [REM_W:0]      trial;
  logic [REM_W:0]      diff;
  logic                ge;
  logic                in_fire;
  logic                out_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign full     = (fill_q == FILL_W'(WINDOW));

  // game delta from the tick
  assign real_delta = in_i.now_ms - last_q;
  always_comb begin
    if (paused_q) begin
      sel_delta = '0;
    end else if (slow_q) begin
      sel_delta = {1'b0, real_delta[TIME_W-1:1]};
    end else begin
      sel_delta = real_delta;
    end
    g_d = (|sel_delta[TIME_W-1:DELTA_W]) ? '1 : sel_delta[DELTA_W-1:0];
  end

  // window sum and sleep
  always_comb begin
    sum_d = sum_q + {{(SUM_W-DELTA_W){1'b0}}, g_q};
    if (full) begin
      sum_d = sum_d - {{(SUM_W-DELTA_W){1'b0}}, ring_rdata};
    end
    if (g_q < {{(DELTA_W-MS_W){1'b0}}, period_q}) begin
      sleep_d = period_q - g_q[MS_W-1:0];
    end else begin
      sleep_d = '0;
    end
  end

  // restoring divider step
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  fpfm_ram #(
    .WIDTH(DELTA_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl.upd_en),
    .waddr_i (ptr_q),
    .wdata_i (g_q),
    .raddr_i (ptr_q),
    .rdata_o (ring_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_UPDATE;
      end
      ST_UPDATE:   state_d = ST_LOAD_AVG;
      ST_LOAD_AVG: state_d = ST_DIV_AVG;
      ST_DIV_AVG: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_LOAD_FPS;
      end
      ST_LOAD_FPS: state_d = ST_DIV_FPS;
      ST_DIV_FPS: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:     ctrl.in_ready = 1'b1;
      ST_UPDATE:   ctrl.upd_en   = 1'b1;
      ST_LOAD_AVG: ctrl.ld_avg   = 1'b1;
      ST_DIV_AVG:  ctrl.div_step = 1'b1;
      ST_LOAD_FPS: ctrl.ld_fps   = 1'b1;
      ST_DIV_FPS:  ctrl.div_step = 1'b1;
      ST_FINISH:   ctrl.out_load = !out_valid_q || out_o.ready;
      default:     ctrl = '0;
    endcase
  end

  assign in_i.ready = ctrl.in_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      paused_q    <= 1'b0;
      slow_q      <= 1'b0;
      period_q    <= MS_W'(PERIOD_RST);
      last_q      <= '0;
      total_q     <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.reg_idx))
          REG_PAUSED:       paused_q <= cfg_i.wdata[0];
          REG_SLOW_MOTION:  slow_q   <= cfg_i.wdata[0];
          REG_FRAME_PERIOD: period_q <= cfg_i.wdata[MS_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        last_q <= in_i.now_ms;
      end
      if (ctrl.upd_en) begin
        sum_q   <= sum_d;
        total_q <= total_q + {{(TIME_W-DELTA_W){1'b0}}, g_q}
                           + {{(TIME_W-MS_W){1'b0}}, sleep_d};
        ptr_q   <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
        if (!full) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
      if (ctrl.ld_avg) begin
        cnt_q <= CNT_W'(SUM_W);
      end else if (ctrl.ld_fps) begin
        cnt_q <= CNT_W'(FPS_W);
      end else if (ctrl.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      g_q <= g_d;
    end
    if (ctrl.upd_en) begin
      sleep_q <= sleep_d;
    end
    if (ctrl.ld_avg) begin
      rem_q <= '0;
      dvd_q <= sum_q;
      quo_q <= '0;
      dvs_q <= {{(REM_W-FILL_W){1'b0}}, fill_q};
    end else if (ctrl.ld_fps) begin
      avg_q <= quo_q[DELTA_W-1:0];
      rem_q <= '0;
      dvd_q <= SUM_W'(FPS_SCALE) << (SUM_W - FPS_W);
      quo_q <= '0;
      dvs_q <= quo_q[DELTA_W-1:0];
    end else if (ctrl.div_step) begin
      rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
    if (ctrl.out_load) begin
      out_delta_q <= g_q;
      out_time_q  <= total_q;
      out_sleep_q <= sleep_q;
      out_avg_q   <= avg_q;
      out_fps_q   <= (avg_q == '0) ? '0 : quo_q[FPS_W-1:0];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.game_delta        = out_delta_q;
  assign out_o.game_time         = out_time_q;
  assign out_o.sleep_ms          = out_sleep_q;
  assign out_o.average_delta     = out_avg_q;
  assign out_o.frames_per_second = out_fps_q;

endmodule

[tb/tb_frame_pacer_fps_meter.sv]
// self-checking testbench for the frame pacer and sliding-window fps meter
`timescale 1ns / 1ps
module tb_frame_pacer_fps_meter;
  import fpfm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned SEG_ITEMS = 229;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [DELTA_W-1:0] game_delta;
    logic [TIME_W-1:0]  game_time;
    logic [MS_W-1:0]    sleep_ms;
    logic [DELTA_W-1:0] average_delta;
    logic [FPS_W-1:0]   frames_per_second;
  } frame_stats_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fpfm_in_if  tick_if ();
  fpfm_out_if stats_if ();
  fpfm_cfg_if reg_if ();

  frame_pacer_fps_meter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (stats_if),
    .cfg_i  (reg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [TIME_W-1:0] tick_q [$];
  reg_write_t        reg_q [$];
  frame_stats_t      stats_q [$];
  int unsigned       src_idle_pct;
  int unsigned       snk_stall_pct;
  int unsigned       mismatches;
  logic [TIME_W-1:0] stamp_gen;

  // pacer state and settings as the block should hold them
  logic                cfg_paused;
  logic                cfg_slow;
  logic [MS_W-1:0]     cfg_period;
  logic [TIME_W-1:0]   stamp_last;
  logic [TIME_W-1:0]   game_clock;
  logic [DELTA_W-1:0]  ring_mem [WINDOW];
  int unsigned         ring_wr;
  int unsigned         ring_fill;
  longint unsigned     ring_sum;

  task automatic add_tick(input logic [TIME_W-1:0] ts);
    tick_q = {tick_q, ts};
  endtask

  task automatic pacer_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PAUSED:       cfg_paused = data[0];
      REG_SLOW_MOTION:  cfg_slow = data[0];
      REG_FRAME_PERIOD: cfg_period = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic pacer_tick(input logic [TIME_W-1:0] ts);
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  scaled;
    logic [DELTA_W-1:0] gd;
    logic [MS_W-1:0]    slp;
    longint unsigned    mean;
    frame_stats_t       s;
    span = ts - stamp_last;
    stamp_last = ts;
    if (cfg_paused) begin
      scaled = '0;
    end else if (cfg_slow) begin
      scaled = span >> 1;
    end else begin
      scaled = span;
    end
    gd = (scaled[TIME_W-1:DELTA_W] != '0) ? '1 : scaled[DELTA_W-1:0];
    if (ring_fill >= WINDOW) begin
      ring_sum -= ring_mem[ring_wr];
    end else begin
      ring_fill++;
    end
    ring_mem[ring_wr] = gd;
    ring_sum += gd;
    ring_wr = (ring_wr + 1) % WINDOW;
    mean = ring_sum / ring_fill;
    slp = (gd < cfg_period) ? MS_W'(cfg_period - gd) : '0;
    game_clock = game_clock + gd + slp;
    s.game_delta = gd;
    s.game_time = game_clock;
    s.sleep_ms = slp;
    s.average_delta = mean[DELTA_W-1:0];
    s.frames_per_second = (mean > 0) ? FPS_W'(FPS_SCALE / mean) : '0;
    stats_q = {stats_q, s};
  endtask

  // mostly steady frame timing, with a share of jumps, rewinds and saturating gaps
  function automatic logic [TIME_W-1:0] next_stamp(input int unsigned noise_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < noise_pct) begin
      case ($urandom_range(2))
        0: stamp_gen = $urandom();
        1: stamp_gen = stamp_gen - $urandom_range(500);
        default: stamp_gen = stamp_gen + $urandom_range(300000, 60000);
      endcase
    end else if (r < 85) begin
      stamp_gen = stamp_gen + $urandom_range(60);
    end else begin
      stamp_gen = stamp_gen + $urandom_range(2500);
    end
    return stamp_gen;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || tick_if.valid || stats_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    wait_idle();
    w.idx = idx;
    w.data = data;
    reg_q = {reg_q, w};
    do @(negedge clk_i);
    while (reg_q.size() != 0 || reg_if.valid);
  endtask

  // flag registers get random upper bits, only bit 0 counts
  task automatic write_flag(input logic [CFG_IDX_W-1:0] idx, input logic bit_val);
    write_reg(idx, {(CFG_DATA_W-1)'($urandom_range(511)), bit_val});
  endtask

  always @(posedge clk_i) begin : tick_drive
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else if (!tick_if.valid || tick_if.ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        tick_if.valid <= 1'b1;
        tick_if.now_ms <= tick_q[0];
        tick_q.delete(0);
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : reg_drive
    reg_write_t w;
    if (!rst_ni) begin
      reg_if.valid <= 1'b0;
    end else if (!reg_if.valid || reg_if.ready) begin
      if (reg_q.size() != 0) begin
        w = reg_q[0];
        reg_q.delete(0);
        reg_if.valid <= 1'b1;
        reg_if.reg_idx <= w.idx;
        reg_if.wdata <= w.data;
      end else begin
        reg_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : stats_accept
    if (!rst_ni) begin
      stats_if.ready <= 1'b0;
    end else begin
      stats_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin : score
    frame_stats_t want;
    if (rst_ni) begin
      if (reg_if.valid && reg_if.ready) pacer_write(reg_if.reg_idx, reg_if.wdata);
      if (tick_if.valid && tick_if.ready) pacer_tick(tick_if.now_ms);
      if (stats_if.valid && stats_if.ready) begin
        if (stats_q.size() == 0) begin
          $error("result word with no tick pending");
          mismatches++;
        end else begin
          want = stats_q[0];
          stats_q.delete(0);
          if (stats_if.game_delta !== want.game_delta) begin
            $error("game_delta: expected %0d, got %0d", want.game_delta, stats_if.game_delta);
            mismatches++;
          end
          if (stats_if.game_time !== want.game_time) begin
            $error("game_time: expected %0d, got %0d", want.game_time, stats_if.game_time);
            mismatches++;
          end
          if (stats_if.sleep_ms !== want.sleep_ms) begin
            $error("sleep_ms: expected %0d, got %0d", want.sleep_ms, stats_if.sleep_ms);
            mismatches++;
          end
          if (stats_if.average_delta !== want.average_delta) begin
            $error("average_delta: expected %0d, got %0d",
                   want.average_delta, stats_if.average_delta);
            mismatches++;
          end
          if (stats_if.frames_per_second !== want.frames_per_second) begin
            $error("frames_per_second: expected %0d, got %0d",
                   want.frames_per_second, stats_if.frames_per_second);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("frame_pacer_fps_meter regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned noise_pct;
    rst_ni = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.now_ms = '0;
    reg_if.valid = 1'b0;
    reg_if.reg_idx = '0;
    reg_if.wdata = '0;
    stats_if.ready = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    mismatches = 0;
    stamp_gen = '0;
    cfg_paused = 1'b0;
    cfg_slow = 1'b0;
    cfg_period = MS_W'(PERIOD_RST);
    stamp_last = '0;
    game_clock = '0;
    ring_wr = 0;
    ring_fill = 0;
    ring_sum = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first frame, exact period, wraps, saturation edges, zero delta
    add_tick(32'd1);
    add_tick(32'd41);
    add_tick(32'd80);
    add_tick(32'd0);
    add_tick(32'hFFFF_FFFF);
    add_tick(32'h0000_0010);
    add_tick(32'h0001_000F);
    add_tick(32'h0002_000F);
    add_tick(32'h0002_000F);
    add_tick(32'h0002_03F7);
    write_reg(REG_FRAME_PERIOD, 10'd0);
    add_tick(32'h0002_03F8);
    write_reg(REG_FRAME_PERIOD, 10'd1023);
    add_tick(32'h0002_03F8);
    add_tick(32'h0002_07F7);
    write_reg(REG_SPARE, 10'd1);
    write_reg(REG_FRAME_PERIOD, 10'd1);
    write_flag(REG_PAUSED, 1'b1);
    add_tick(32'h0003_0000);
    write_flag(REG_SLOW_MOTION, 1'b1);
    add_tick(32'h0000_0005);
    write_flag(REG_PAUSED, 1'b0);
    add_tick(32'h0000_0006);
    add_tick(32'h0002_0005);
    add_tick(32'h0004_0003);
    add_tick(32'h0004_0002);
    add_tick(32'h0004_0005);
    write_flag(REG_SLOW_MOTION, 1'b0);
    add_tick(32'h0004_0005);
    stamp_gen = 32'h0004_0005;

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      case (seg)
        0: write_reg(REG_FRAME_PERIOD, 10'd40);
        1: write_reg(REG_FRAME_PERIOD, 10'd1000);
        2: write_reg(REG_FRAME_PERIOD, 10'd1);
        3: write_reg(REG_FRAME_PERIOD, 10'd0);
        4: write_reg(REG_FRAME_PERIOD, 10'd1023);
        5: write_reg(REG_FRAME_PERIOD, CFG_DATA_W'($urandom_range(1, 60)));
        6: write_reg(REG_FRAME_PERIOD, 10'd500);
        default: write_reg(REG_FRAME_PERIOD, CFG_DATA_W'($urandom_range(1023)));
      endcase
      write_flag(REG_PAUSED, seg == 2 || seg == 6);
      write_flag(REG_SLOW_MOTION, seg == 1 || seg == 4 || seg == 6);
      noise_pct = (seg == 3 || seg == 7) ? 8 : (seg == 5 ? 2 : 0);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i == SEG_ITEMS / 2) wait_idle();
        add_tick(next_stamp(noise_pct));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && stats_q.size() == 0) begin
      $display("frame_pacer_fps_meter regression: pass");
    end else begin
      $display("frame_pacer_fps_meter regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fpfm_pkg.sv
rtl/fpfm_in_if.sv
rtl/fpfm_out_if.sv
rtl/fpfm_cfg_if.sv
rtl/fpfm_ram.sv
rtl/frame_pacer_fps_meter.sv
tb/tb_frame_pacer_fps_meter.sv
